>>> rtl/core/i2c_target_bit_fsm_assert.svh
// Assertion macros for the I2C target bit-level state machine.
// Used by the checker file; expects clk, arst_n and res_valid in the enclosing scope.
`ifndef I2C_TARGET_BIT_FSM_ASSERT_SVH
`define I2C_TARGET_BIT_FSM_ASSERT_SVH

// check cons in any cycle where a result is on offer and ante holds
`define I2CTBF_ON_RES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		res_valid && (ante) |-> (cons)) else $error(msg);

// check cons in the cycle after ante
`define I2CTBF_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/i2ctbf_pkg.sv
`timescale 1ns / 1ps
// Package for the I2C target bit-level state machine: phase codes, bus event
// codes, bit-mask constants and the transfer payload structs. No dependencies.
package i2ctbf_pkg;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ADDR = 3'd1,
		PH_DACK = 3'd2,
		PH_RX   = 3'd3,
		PH_TX   = 3'd4,
		PH_SACK = 3'd5
	} phase_t;

	// bus event codes
	localparam logic [2:0] OP_START   = 3'd0;
	localparam logic [2:0] OP_STOP    = 3'd1;
	localparam logic [2:0] OP_RISE_HI = 3'd2;
	localparam logic [2:0] OP_RISE_LO = 3'd3;
	localparam logic [2:0] OP_FALL    = 3'd4;

	localparam logic [7:0] BIT_FIRST = 8'h80; // first bit of a byte, MSB first
	localparam logic [7:0] DIR_BIT   = 8'h01; // read/write bit of the address byte

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] tx_data;
		logic       rx_accept;
	} in_item_t;

	typedef struct packed {
		logic       sda_write;
		logic       sda_level;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       tx_taken;
		logic [7:0] byte_number;
		logic       stop_event;
		logic [2:0] phase;
	} out_item_t;

	// byte-level context carried from one event to the next
	typedef struct packed {
		phase_t     phase;
		logic [7:0] shift;
		logic [7:0] mask;
		logic       ack;
		logic       rd;
	} core_state_t;

endpackage

>>> rtl/core/i2ctbf_step.sv
`timescale 1ns / 1ps
// Combinational event step: next context and result for one bus event.
// Depends on i2ctbf_pkg.
module i2ctbf_step #(
	parameter int INDEX_BITS = 8
) (
	input  i2ctbf_pkg::core_state_t cur,
	input  logic [INDEX_BITS-1:0]   cnt,
	input  logic [6:0]              own_address,
	input  i2ctbf_pkg::in_item_t    item,
	output i2ctbf_pkg::core_state_t nxt,
	output logic [INDEX_BITS-1:0]   cnt_nxt,
	output i2ctbf_pkg::out_item_t   res
);

	localparam int EXT_W = (INDEX_BITS > 8) ? INDEX_BITS : 8;

	logic [EXT_W-1:0] cnt_ext;
	logic [7:0]       cnt_rep;
	logic             addr_hit;

	assign cnt_ext  = EXT_W'(cnt);
	assign cnt_rep  = cnt_ext[7:0];
	assign addr_hit = (cur.shift[7:1] == own_address);

	// next state
	always_comb begin
		nxt     = cur;
		cnt_nxt = cnt;
		unique case (item.opcode)
			i2ctbf_pkg::OP_START: begin
				nxt.phase = i2ctbf_pkg::PH_ADDR;
				nxt.shift = '0;
				nxt.mask  = i2ctbf_pkg::BIT_FIRST;
				cnt_nxt   = '0;
			end
			i2ctbf_pkg::OP_STOP: begin
				nxt.phase = i2ctbf_pkg::PH_IDLE;
			end
			i2ctbf_pkg::OP_RISE_HI, i2ctbf_pkg::OP_RISE_LO: begin
				if (cur.phase == i2ctbf_pkg::PH_ADDR || cur.phase == i2ctbf_pkg::PH_RX) begin
					if (item.opcode == i2ctbf_pkg::OP_RISE_HI) begin
						nxt.shift = cur.shift | cur.mask;
					end
					nxt.mask = cur.mask >> 1;
				end else if (cur.phase == i2ctbf_pkg::PH_SACK) begin
					nxt.ack = (item.opcode == i2ctbf_pkg::OP_RISE_LO);
				end
			end
			i2ctbf_pkg::OP_FALL: begin
				unique case (cur.phase)
					i2ctbf_pkg::PH_ADDR: begin
						if (cur.mask == '0) begin
							nxt.rd    = |(cur.shift & i2ctbf_pkg::DIR_BIT);
							nxt.ack   = addr_hit;
							nxt.phase = i2ctbf_pkg::PH_DACK;
						end
					end
					i2ctbf_pkg::PH_DACK: begin
						if (!cur.ack) begin
							nxt.phase = i2ctbf_pkg::PH_IDLE;
						end else if (cur.rd) begin
							nxt.phase = i2ctbf_pkg::PH_TX;
							nxt.shift = item.tx_data;
							nxt.mask  = i2ctbf_pkg::BIT_FIRST >> 1;
							cnt_nxt   = cnt + INDEX_BITS'(1);
						end else begin
							nxt.phase = i2ctbf_pkg::PH_RX;
							nxt.shift = '0;
							nxt.mask  = i2ctbf_pkg::BIT_FIRST;
						end
					end
					i2ctbf_pkg::PH_RX: begin
						if (cur.mask == '0) begin
							cnt_nxt   = cnt + INDEX_BITS'(1);
							nxt.ack   = item.rx_accept;
							nxt.phase = i2ctbf_pkg::PH_DACK;
						end
					end
					i2ctbf_pkg::PH_TX: begin
						if (cur.mask != '0) begin
							nxt.mask = cur.mask >> 1;
						end else begin
							nxt.phase = i2ctbf_pkg::PH_SACK;
						end
					end
					i2ctbf_pkg::PH_SACK: begin
						if (cur.ack) begin
							nxt.phase = i2ctbf_pkg::PH_TX;
							nxt.shift = item.tx_data;
							nxt.mask  = i2ctbf_pkg::BIT_FIRST >> 1;
							cnt_nxt   = cnt + INDEX_BITS'(1);
						end else begin
							nxt.phase = i2ctbf_pkg::PH_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// result
	always_comb begin
		res       = '0;
		res.phase = nxt.phase;
		unique case (item.opcode)
			i2ctbf_pkg::OP_STOP: begin
				res.sda_write  = 1'b1;
				res.sda_level  = 1'b1;
				res.stop_event = 1'b1;
			end
			i2ctbf_pkg::OP_FALL: begin
				unique case (cur.phase)
					i2ctbf_pkg::PH_ADDR: begin
						if (cur.mask == '0) begin
							res.sda_write = 1'b1;
							res.sda_level = !addr_hit;
						end
					end
					i2ctbf_pkg::PH_DACK: begin
						res.sda_write = 1'b1;
						if (cur.ack && cur.rd) begin
							res.tx_taken    = 1'b1;
							res.byte_number = cnt_rep;
							res.sda_level   = |(item.tx_data & i2ctbf_pkg::BIT_FIRST);
						end else begin
							res.sda_level = 1'b1;
						end
					end
					i2ctbf_pkg::PH_RX: begin
						if (cur.mask == '0) begin
							res.rx_valid    = 1'b1;
							res.rx_byte     = cur.shift;
							res.byte_number = cnt_rep;
							res.sda_write   = 1'b1;
							res.sda_level   = !item.rx_accept;
						end
					end
					i2ctbf_pkg::PH_TX: begin
						res.sda_write = 1'b1;
						res.sda_level = (cur.mask != '0) ? |(cur.shift & cur.mask) : 1'b1;
					end
					i2ctbf_pkg::PH_SACK: begin
						res.sda_write = 1'b1;
						if (cur.ack) begin
							res.tx_taken    = 1'b1;
							res.byte_number = cnt_rep;
							res.sda_level   = |(item.tx_data & i2ctbf_pkg::BIT_FIRST);
						end else begin
							res.sda_level = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/core/i2c_target_bit_fsm.sv
`timescale 1ns / 1ps
// I2C target bit-level state machine, top level: event input stage, context
// registers and result stage. Depends on i2ctbf_pkg and i2ctbf_step.

// One bus event per transfer goes in (start, stop, SCL rise with SDA high or
// low, SCL fall) and exactly one result comes out for it, in order. The block
// takes one event every clock while each result is taken: an event waits in
// the input stage, is decoded there by a single combinational step that also
// updates the byte context, and its result is held in the output stage until
// the consumer takes it, so a result is on offer once its event has passed
// through the input stage and been registered in the output stage. A stalled
// output only blocks the input once both stages are full. The address byte
// is shifted in MSB first and its upper seven bits are compared with
// own_address; write own_address through cfg_we/cfg_wdata only while no
// event is in flight. byte_number reports the low eight bits of an
// INDEX_BITS-wide byte counter that wraps.
module i2c_target_bit_fsm #(
	parameter int INDEX_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [6:0]            cfg_wdata,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  i2ctbf_pkg::in_item_t  item,
	output logic                  res_valid,
	input  logic                  res_ready,
	output i2ctbf_pkg::out_item_t res
);

	logic                    valid_s1;
	i2ctbf_pkg::in_item_t    item_s1;
	logic                    valid_s2;
	i2ctbf_pkg::out_item_t   res_s2;

	logic [6:0]              own_address_q;
	i2ctbf_pkg::core_state_t ctx_q;
	logic [INDEX_BITS-1:0]   cnt_q;

	i2ctbf_pkg::core_state_t ctx_nxt;
	logic [INDEX_BITS-1:0]   cnt_nxt;
	i2ctbf_pkg::out_item_t   res_nxt;

	logic                    move_s1;

	// advance the input stage whenever the result stage is free or draining
	assign move_s1    = valid_s1 && (!valid_s2 || res_ready);
	assign item_ready = !valid_s1 || move_s1;

	i2ctbf_step #(
		.INDEX_BITS(INDEX_BITS)
	) u_step (
		.cur        (ctx_q),
		.cnt        (cnt_q),
		.own_address(own_address_q),
		.item       (item_s1),
		.nxt        (ctx_nxt),
		.cnt_nxt    (cnt_nxt),
		.res        (res_nxt)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
		end else if (cfg_we) begin
			own_address_q <= cfg_wdata;
		end
	end

	// input stage: hold the event until the step consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// byte context: commit only when the event moves into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '{phase: i2ctbf_pkg::PH_IDLE, shift: '0, mask: '0, ack: 1'b0, rd: 1'b0};
			cnt_q <= '0;
		end else if (move_s1) begin
			ctx_q <= ctx_nxt;
			cnt_q <= cnt_nxt;
		end
	end

	// result stage: hold the result while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || res_ready) begin
			valid_s2 <= move_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

>>> rtl/core/i2ctbf_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the I2C target bit-level state machine, bound to the
// top level. Depends on i2ctbf_pkg and i2c_target_bit_fsm_assert.svh.
`include "i2c_target_bit_fsm_assert.svh"

module i2ctbf_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  res_valid,
	input logic                  res_ready,
	input i2ctbf_pkg::out_item_t res
);

	logic stalled;
	logic drv;
	logic sda_rel;
	logic ph_idle;
	logic ph_dack;
	logic ph_tx;

	assign stalled = res_valid && !res_ready;
	assign drv     = res.sda_write;
	assign sda_rel = res.sda_write && res.sda_level;
	assign ph_idle = (res.phase == i2ctbf_pkg::PH_IDLE);
	assign ph_dack = (res.phase == i2ctbf_pkg::PH_DACK);
	assign ph_tx   = (res.phase == i2ctbf_pkg::PH_TX);

	`I2CTBF_NEXT(a_res_hold, stalled, res_valid && $stable(res), "result moved in stall")
	`I2CTBF_ON_RES(a_rx_to_ack, res.rx_valid, drv && ph_dack, "rx byte without ack")
	`I2CTBF_ON_RES(a_stop_idle, res.stop_event, sda_rel && ph_idle, "stop not idle")
	`I2CTBF_ON_RES(a_tx_phase, res.tx_taken, drv && !res.rx_valid && ph_tx, "tx outside transmit")
	`I2CTBF_ON_RES(a_sda_quiet, !res.sda_write, !res.sda_level, "level without write")

endmodule

bind i2c_target_bit_fsm i2ctbf_checker u_i2ctbf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res      (res)
);
